[rtl/assert_macros.svh]
// Assertion macros shared by the poller RTL.
// Each macro takes a label, a property expression and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define SPHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, during reset too.
`define SPHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/sphs_pkg.sv]
// Package for the sensor poll health sequencer: item and state types,
// request codes, register indexes and bus constants. No dependencies.
`default_nettype none

package sphs_pkg;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_PROBE   = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic [1:0] CFG_READ_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_CONV_WAIT     = 2'd1;
  localparam logic [1:0] CFG_RETRY         = 2'd2;
  localparam logic [1:0] CFG_MAX_FAIL      = 2'd3;

  localparam logic [7:0]  ADDR_CONFIG    = 8'h00;
  localparam logic [7:0]  ADDR_VOLTAGE   = 8'h02;
  localparam logic [7:0]  ADDR_ID        = 8'hFE;
  localparam logic [15:0] ID_EXPECTED    = 16'h5449;
  localparam logic [15:0] CONFIG_DEFAULT = 16'h4127;
  localparam logic [15:0] MODE_MASK      = 16'h0007;
  localparam logic [15:0] MODE_TRIGGERED = 16'h0002;
  localparam logic [15:0] TRIGGER_WORD   = (CONFIG_DEFAULT & ~MODE_MASK) | MODE_TRIGGERED;
  localparam logic [10:0] UV_PER_CODE    = 11'd1250;
  localparam logic [7:0]  FAIL_SAT       = 8'd255;

  localparam logic [31:0] READ_INTERVAL_RST = 32'd1000;
  localparam logic [31:0] CONV_WAIT_RST     = 32'd3;
  localparam logic [31:0] RETRY_RST         = 32'd5000;
  localparam logic [7:0]  MAX_FAIL_RST      = 8'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic        bus_ok;
    logic [15:0] bus_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  request;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        healthy;
    logic [26:0] voltage_uv;
    logic [7:0]  fail_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] read_interval_ms;
    logic [31:0] conversion_wait_ms;
    logic [31:0] retry_interval_ms;
    logic [7:0]  max_fail_count;
  } cfg_t;

  typedef struct packed {
    logic        is_healthy;
    logic        probe_needed;
    logic        phase_waiting;
    op_t         pending_op;
    logic [31:0] pending_time;
    logic [7:0]  failures;
    logic [31:0] last_retry_time;
    logic [31:0] last_read_time;
    logic [31:0] trigger_time;
    logic [26:0] last_voltage;
  } state_t;

endpackage

`default_nettype wire

[rtl/sphs_core.sv]
// Decision logic for one item: next poller state and the result item.
// Depends on sphs_pkg.
`default_nettype none

module sphs_core (
  input  sphs_pkg::in_item_t  item,
  input  sphs_pkg::cfg_t      cfg,
  input  sphs_pkg::state_t    st,
  output sphs_pkg::state_t    st_next,
  output sphs_pkg::out_item_t result
);
  import sphs_pkg::*;

  logic [31:0] base_time;
  logic [31:0] interval;
  logic [31:0] elapsed;
  logic        due;
  logic [7:0]  fail_inc;
  logic        fail_limit;
  logic [26:0] product;
  op_t         req;

  always_comb begin
    if (!st.is_healthy) begin
      base_time = st.last_retry_time;
      interval  = cfg.retry_interval_ms;
    end else if (!st.phase_waiting) begin
      base_time = st.last_read_time;
      interval  = cfg.read_interval_ms;
    end else begin
      base_time = st.trigger_time;
      interval  = cfg.conversion_wait_ms;
    end
    elapsed = item.now_ms - base_time;
    due     = elapsed >= interval;
  end

  assign fail_inc   = (st.failures != FAIL_SAT) ? st.failures + 8'd1 : st.failures;
  assign fail_limit = fail_inc >= cfg.max_fail_count;
  assign product    = 27'(item.bus_data) * 27'(UV_PER_CODE);

  always_comb begin
    st_next = st;
    req     = OP_NONE;
    if (!item.kind) begin
      if (st.pending_op == OP_NONE) begin
        if (st.probe_needed) begin
          st_next.probe_needed = 1'b0;
          req = OP_PROBE;
        end else if (due) begin
          if (!st.is_healthy) begin
            req = OP_PROBE;
          end else if (!st.phase_waiting) begin
            req = OP_TRIGGER;
          end else begin
            req = OP_READ;
          end
        end
        if (req != OP_NONE) begin
          st_next.pending_op   = req;
          st_next.pending_time = item.now_ms;
        end
      end
    end else begin
      st_next.pending_op = OP_NONE;
      case (st.pending_op)
        OP_PROBE: begin
          if (item.bus_ok && item.bus_data == ID_EXPECTED) begin
            st_next.is_healthy    = 1'b1;
            st_next.failures      = 8'd0;
            st_next.phase_waiting = 1'b0;
          end else begin
            st_next.is_healthy = 1'b0;
          end
          st_next.last_retry_time = st.pending_time;
        end
        OP_TRIGGER: begin
          if (item.bus_ok) begin
            st_next.trigger_time  = st.pending_time;
            st_next.phase_waiting = 1'b1;
          end else begin
            st_next.failures       = fail_inc;
            st_next.last_read_time = st.pending_time;
            if (fail_limit) begin
              st_next.is_healthy      = 1'b0;
              st_next.last_retry_time = st.pending_time;
            end
          end
        end
        OP_READ: begin
          if (item.bus_ok) begin
            st_next.last_voltage = product;
            st_next.failures     = 8'd0;
          end else begin
            st_next.failures = fail_inc;
            if (fail_limit) begin
              st_next.is_healthy      = 1'b0;
              st_next.last_retry_time = st.pending_time;
            end
          end
          st_next.last_read_time = st.pending_time;
          st_next.phase_waiting  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.request    = req;
    result.reg_addr   = 8'h00;
    result.write_data = 16'h0000;
    case (req)
      OP_PROBE:   result.reg_addr = ADDR_ID;
      OP_TRIGGER: begin
        result.reg_addr   = ADDR_CONFIG;
        result.write_data = TRIGGER_WORD;
      end
      OP_READ:    result.reg_addr = ADDR_VOLTAGE;
      default:    result.reg_addr = 8'h00;
    endcase
    result.healthy    = st_next.is_healthy;
    result.voltage_uv = st_next.last_voltage;
    result.fail_count = st_next.failures;
  end

endmodule

`default_nettype wire

[rtl/sensor_poll_health_sequencer.sv]
// Top level of the sensor poll health sequencer: input register, state and
// result register, APB register file. Depends on sphs_pkg, sphs_core and
// assert_macros.svh.
//
// Usage:
// Items arrive on item/item_valid/item_ready: a tick carries the millisecond
// time, a response carries the bus outcome of the last request issued.
// Every item yields exactly one result on result/result_valid/result_ready,
// in order. The result names the bus request to start (or none) and the
// health, last voltage in microvolts and failure count after the item.
// An item is registered in the input register, where the decision is made,
// and its result is then registered in the result register, which raises
// result_valid. Throughput is one item per cycle while the receiver takes
// results; the decision logic is combinational and updates the poller
// state as the item leaves the input register.
// When the receiver stalls, the result register holds its item, the input
// register holds one more, and item_ready then drops until a transfer
// on the result side.
// Reset (synchronous, active high) loads the register defaults and clears
// the poller state; the first tick after reset requests an ID probe.
// Registers are written over APB at byte addresses 0, 4, 8 and 12.
`default_nettype none

module sensor_poll_health_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  sphs_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output sphs_pkg::out_item_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sphs_pkg::*;
  `include "assert_macros.svh"

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  in_item_t  hold;
  logic      hold_valid;
  logic      result_free;
  logic      advance;
  out_item_t step_result;
  logic      cfg_write;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign result_free = !result_valid || result_ready;
  assign advance     = hold_valid && result_free;
  assign item_ready  = !hold_valid || result_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_interval_ms   <= READ_INTERVAL_RST;
      cfg.conversion_wait_ms <= CONV_WAIT_RST;
      cfg.retry_interval_ms  <= RETRY_RST;
      cfg.max_fail_count     <= MAX_FAIL_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        CFG_READ_INTERVAL: cfg.read_interval_ms   <= pwdata;
        CFG_CONV_WAIT:     cfg.conversion_wait_ms <= pwdata;
        CFG_RETRY:         cfg.retry_interval_ms  <= pwdata;
        CFG_MAX_FAIL:      cfg.max_fail_count     <= pwdata[7:0];
        default:           cfg.max_fail_count     <= cfg.max_fail_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_READ_INTERVAL: prdata = cfg.read_interval_ms;
      CFG_CONV_WAIT:     prdata = cfg.conversion_wait_ms;
      CFG_RETRY:         prdata = cfg.retry_interval_ms;
      CFG_MAX_FAIL:      prdata = {24'd0, cfg.max_fail_count};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold <= item;
    end
  end

  sphs_core u_core (
    .item    (hold),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.is_healthy      <= 1'b0;
      st.probe_needed    <= 1'b1;
      st.phase_waiting   <= 1'b0;
      st.pending_op      <= OP_NONE;
      st.pending_time    <= 32'd0;
      st.failures        <= 8'd0;
      st.last_retry_time <= 32'd0;
      st.last_read_time  <= 32'd0;
      st.trigger_time    <= 32'd0;
      st.last_voltage    <= 27'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  `SPHS_ASSERT(a_no_advance_on_stall, !(advance && result_valid && !result_ready),
    "input register advanced over a stalled result")
  `SPHS_ASSERT(a_busy_tick_no_request,
    (advance && !hold.kind && st.pending_op != OP_NONE) |=> (result.request == OP_NONE),
    "tick with a request outstanding issued a request")
  `SPHS_ASSERT(a_idle_fields_zero,
    (result_valid && result.request == OP_NONE) |->
      (result.reg_addr == 8'h00 && result.write_data == 16'h0000),
    "result without request carries an address or write word")
  `SPHS_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (!hold_valid && !result_valid),
    "pipeline not empty after reset")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for sensor_poll_health_sequencer: a queue-fed driver,
// a randomly stalling sink and a monitor that checks each result against a
// predictor of the poller. Depends on sphs_pkg and the block's RTL.
`default_nettype none

module tb_top;
  import sphs_pkg::*;

  localparam int STUCK_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  in_item_t  queued_items[$];
  out_item_t expected_results[$];
  state_t    model_state;
  state_t    gen_state;
  cfg_t      cfg_shadow;
  logic [31:0] gen_now = '0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned stuck_cycles = 0;
  int unsigned errors = 0;
  logic quiet = 1'b0;

  sensor_poll_health_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic state_t poller_reset_state();
    state_t s;
    s = '0;
    s.probe_needed = 1'b1;
    s.pending_op = OP_NONE;
    return s;
  endfunction

  function automatic void count_failure(inout state_t s, input cfg_t c);
    if (s.failures < FAIL_SAT) begin
      s.failures = s.failures + 8'd1;
    end
    if (s.failures >= c.max_fail_count) begin
      s.is_healthy = 1'b0;
      s.last_retry_time = s.pending_time;
    end
  endfunction

  function automatic out_item_t next_poll_result(inout state_t s, input cfg_t c,
                                                 input in_item_t it);
    out_item_t r;
    op_t req;
    op_t done_op;
    logic [31:0] elapsed;
    r = '0;
    req = OP_NONE;
    if (it.kind == 1'b0) begin
      if (s.pending_op == OP_NONE) begin
        if (s.probe_needed) begin
          s.probe_needed = 1'b0;
          req = OP_PROBE;
        end else if (!s.is_healthy) begin
          elapsed = it.now_ms - s.last_retry_time;
          if (elapsed >= c.retry_interval_ms) req = OP_PROBE;
        end else if (!s.phase_waiting) begin
          elapsed = it.now_ms - s.last_read_time;
          if (elapsed >= c.read_interval_ms) req = OP_TRIGGER;
        end else begin
          elapsed = it.now_ms - s.trigger_time;
          if (elapsed >= c.conversion_wait_ms) req = OP_READ;
        end
        if (req != OP_NONE) begin
          s.pending_op = req;
          s.pending_time = it.now_ms;
        end
      end
    end else begin
      done_op = s.pending_op;
      s.pending_op = OP_NONE;
      case (done_op)
        OP_PROBE: begin
          if (it.bus_ok && it.bus_data == ID_EXPECTED) begin
            s.is_healthy = 1'b1;
            s.failures = '0;
            s.phase_waiting = 1'b0;
          end else begin
            s.is_healthy = 1'b0;
          end
          s.last_retry_time = s.pending_time;
        end
        OP_TRIGGER: begin
          if (it.bus_ok) begin
            s.trigger_time = s.pending_time;
            s.phase_waiting = 1'b1;
          end else begin
            count_failure(s, c);
            s.last_read_time = s.pending_time;
          end
        end
        OP_READ: begin
          if (it.bus_ok) begin
            s.last_voltage = 27'(it.bus_data) * 27'(UV_PER_CODE);
            s.failures = '0;
          end else begin
            count_failure(s, c);
          end
          s.last_read_time = s.pending_time;
          s.phase_waiting = 1'b0;
        end
        default: begin
        end
      endcase
    end
    r.request = req;
    case (req)
      OP_PROBE:   r.reg_addr = ADDR_ID;
      OP_TRIGGER: begin
        r.reg_addr = ADDR_CONFIG;
        r.write_data = TRIGGER_WORD;
      end
      OP_READ:    r.reg_addr = ADDR_VOLTAGE;
      default:    r.reg_addr = '0;
    endcase
    r.healthy = s.is_healthy;
    r.voltage_uv = s.last_voltage;
    r.fail_count = s.failures;
    return r;
  endfunction

  function automatic in_item_t tick_at(logic [31:0] t);
    in_item_t it;
    it.kind = 1'b0;
    it.now_ms = t;
    it.bus_ok = 1'($urandom);
    it.bus_data = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t response(logic ok, logic [15:0] data);
    in_item_t it;
    it.kind = 1'b1;
    it.now_ms = $urandom;
    it.bus_ok = ok;
    it.bus_data = data;
    return it;
  endfunction

  task automatic add_item(input in_item_t it);
    void'(next_poll_result(gen_state, cfg_shadow, it));
    queued_items.push_back(it);
  endtask

  task automatic gen_random(input int count, input int ok_pct, input int probe_ok_pct);
    in_item_t it;
    logic [31:0] base;
    logic [31:0] span;
    for (int n = 0; n < count; n++) begin
      if (gen_state.pending_op != OP_NONE) begin
        if ($urandom_range(0, 99) < 85) begin
          if (gen_state.pending_op == OP_PROBE) begin
            it = response($urandom_range(0, 99) < probe_ok_pct,
                          ($urandom_range(0, 99) < 85) ? ID_EXPECTED : 16'($urandom));
          end else begin
            it = response($urandom_range(0, 99) < ok_pct, 16'($urandom));
          end
        end else begin
          it = tick_at($urandom);
        end
      end else if ($urandom_range(0, 99) < 8) begin
        it = response(1'($urandom), 16'($urandom));
      end else begin
        if (gen_state.probe_needed || !gen_state.is_healthy) begin
          base = gen_state.last_retry_time;
          span = cfg_shadow.retry_interval_ms;
        end else if (!gen_state.phase_waiting) begin
          base = gen_state.last_read_time;
          span = cfg_shadow.read_interval_ms;
        end else begin
          base = gen_state.trigger_time;
          span = cfg_shadow.conversion_wait_ms;
        end
        case ($urandom_range(0, 5))
          0, 1: gen_now = base + span + $urandom_range(0, 2) - 32'd1;
          2:    gen_now = gen_now + $urandom_range(0, 3);
          3:    gen_now = $urandom;
          4:    gen_now = base + $urandom_range(0, span);
          default: gen_now = base + span + $urandom_range(0, 100);
        endcase
        it = tick_at(gen_now);
      end
      add_item(it);
    end
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      CFG_READ_INTERVAL: cfg_shadow.read_interval_ms = val;
      CFG_CONV_WAIT:     cfg_shadow.conversion_wait_ms = val;
      CFG_RETRY:         cfg_shadow.retry_interval_ms = val;
      default:           cfg_shadow.max_fail_count = val[7:0];
    endcase
  endtask

  task automatic set_config(input logic [31:0] rd, input logic [31:0] cw,
                            input logic [31:0] rt, input logic [7:0] mf);
    reg_write(CFG_READ_INTERVAL, rd);
    reg_write(CFG_CONV_WAIT, cw);
    reg_write(CFG_RETRY, rt);
    reg_write(CFG_MAX_FAIL, {24'd0, mf});
  endtask

  task automatic wait_drained();
    while (queued_items.size() != 0 || expected_results.size() != 0 || item_valid) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(next_poll_result(model_state, cfg_shadow, item));
      end
      if (!item_valid || item_ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          item_valid <= 1'b0;
        end else if (queued_items.size() != 0) begin
          item <= queued_items.pop_front();
          item_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 99) < 8) src_gap <= $urandom_range(1, 13);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      result_ready <= 1'b1;
    end else if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      if ($urandom_range(0, 99) < 8) sink_stall <= $urandom_range(1, 13);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none actual %p", $time, result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("request", 32'(want.request), 32'(result.request));
        check_field("reg_addr", 32'(want.reg_addr), 32'(result.reg_addr));
        check_field("write_data", 32'(want.write_data), 32'(result.write_data));
        check_field("healthy", 32'(want.healthy), 32'(result.healthy));
        check_field("voltage_uv", 32'(want.voltage_uv), 32'(result.voltage_uv));
        check_field("fail_count", 32'(want.fail_count), 32'(result.fail_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    model_state = poller_reset_state();
    gen_state = poller_reset_state();
    cfg_shadow.read_interval_ms = READ_INTERVAL_RST;
    cfg_shadow.conversion_wait_ms = CONV_WAIT_RST;
    cfg_shadow.retry_interval_ms = RETRY_RST;
    cfg_shadow.max_fail_count = MAX_FAIL_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk through probing, measuring and falling out of health at reset settings.
    add_item(tick_at(32'd0));
    add_item(tick_at(32'd7));
    add_item(response(1'b1, 16'h5448));
    add_item(tick_at(32'd4999));
    add_item(tick_at(32'd5000));
    add_item(response(1'b0, ID_EXPECTED));
    add_item(response(1'b1, ID_EXPECTED));
    add_item(tick_at(32'd10000));
    add_item(response(1'b1, ID_EXPECTED));
    add_item(tick_at(32'd10000));
    add_item(response(1'b1, 16'h0000));
    add_item(tick_at(32'd10002));
    add_item(tick_at(32'd10003));
    add_item(response(1'b1, 16'hFFFF));
    add_item(tick_at(32'd11002));
    add_item(tick_at(32'd11003));
    add_item(response(1'b0, 16'h0000));
    add_item(tick_at(32'd12003));
    add_item(response(1'b1, 16'hFFFF));
    add_item(tick_at(32'd12006));
    add_item(response(1'b0, 16'hFFFF));
    add_item(tick_at(32'd13006));
    add_item(response(1'b0, 16'h0000));
    add_item(tick_at(32'hFFFF_FFFF));
    add_item(response(1'b1, 16'h0000));
    wait_drained();

    set_config(32'd0, 32'd0, 32'd0, 8'd1);
    gen_random(60, 70, 70);
    wait_drained();

    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    gen_random(50, 80, 80);
    wait_drained();

    set_config(32'd10, 32'd2, 32'd50, 8'd3);
    gen_random(60, 75, 80);
    wait_drained();

    set_config(32'd1, 32'd1, 32'd1, 8'd0);
    gen_random(50, 60, 60);
    wait_drained();

    // Long failing run so the failure count climbs high.
    set_config(32'd0, 32'd0, 32'd0, 8'd255);
    gen_random(150, 0, 100);
    wait_drained();

    set_config(READ_INTERVAL_RST, CONV_WAIT_RST, RETRY_RST, MAX_FAIL_RST);
    gen_random(50, 85, 85);
    wait_drained();

    quiet = 1'b1;
    set_config($urandom_range(0, 20), $urandom_range(0, 5), $urandom_range(0, 40),
               8'($urandom_range(1, 8)));
    gen_random(60, 75, 80);
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/sphs_pkg.sv
rtl/sphs_core.sv
rtl/sensor_poll_health_sequencer.sv
bench/tb_top.sv
